// File: src/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

  // Largest segment count that the tessellator honors.
  localparam int MaxSegments = 256;

  // Depth of the command queue and of the result queue.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // Quotient bits of the texture coordinate divider.
  localparam int DivSteps = 17;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_COL_SEGS = 2'd0;
  localparam logic [1:0] REG_ROW_SEGS = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  // Fixed-point constants.
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] EIGHTH_TURN = 30'h2000_0000;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_QUAD   = 1'b1
  } uvs_cmd_t;

  // Effective configuration seen by the back end.
  typedef struct packed {
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [15:0] radius;
  } uvs_cfg_t;

  // Classified command as it waits in the queue.
  typedef struct packed {
    uvs_cmd_t    cmd;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [16:0] idx;
  } uvs_item_t;

  // Head of the command queue.
  typedef struct packed {
    logic      valid;
    uvs_item_t item;
  } uvs_qhead_t;

  // One result item.
  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
    logic [16:0]        vertex_index;
    logic               last_of_run;
  } uvs_res_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    BK_IDLE,
    BK_QUAD,
    BK_DIV,
    BK_SC_MX,
    BK_SC_MX2,
    BK_SC_X2,
    BK_DM,
    BK_DC,
    BK_HM,
    BK_HN,
    BK_SFIN,
    BK_SSTORE,
    BK_CFIN,
    BK_NX,
    BK_NZ,
    BK_PX,
    BK_PY,
    BK_PZ,
    BK_EMIT
  } uvs_bk_state_t;

  // Segment count as used: zero acts as one, large values clamp.
  function automatic logic [8:0] seg_count(input logic [8:0] r);
    logic [8:0] res;
    if (r == 9'd0) begin
      res = 9'd1;
    end else if (r > 9'(MaxSegments)) begin
      res = 9'(MaxSegments);
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Horner divisors: sine terms first, then cosine terms.
  function automatic logic [5:0] coef_div(input logic [2:0] ci);
    logic [5:0] d;
    unique case (ci)
      3'd0:    d = 6'd42;
      3'd1:    d = 6'd20;
      3'd2:    d = 6'd6;
      3'd3:    d = 6'd56;
      3'd4:    d = 6'd30;
      3'd5:    d = 6'd12;
      default: d = 6'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for the reciprocal multiply.
  function automatic logic [29:0] coef_recip(input logic [2:0] ci);
    logic [29:0] m;
    unique case (ci)
      3'd0:    m = 30'd102261126;
      3'd1:    m = 30'd214748364;
      3'd2:    m = 30'd715827882;
      3'd3:    m = 30'd76695844;
      3'd4:    m = 30'd143165576;
      3'd5:    m = 30'd357913941;
      default: m = 30'd0;
    endcase
    return m;
  endfunction

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? (~66'(v) + 66'd1) : 66'(v);
    r = (m + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  // Round a Q30 value to Q15 and saturate to 16 bits.
  function automatic logic signed [15:0] sat_q15(input logic signed [31:0] v);
    logic [31:0]        m;
    logic [31:0]        r;
    logic signed [17:0] s;
    logic signed [15:0] res;
    m = v[31] ? (~32'(v) + 32'd1) : 32'(v);
    r = (m + 32'h0000_4000) >> 15;
    s = v[31] ? -$signed({1'b0, r[16:0]}) : $signed({1'b0, r[16:0]});
    if (s > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (s < -18'sd32768) begin
      res = -16'sh8000;
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

  // Clamp a Q8.8 position to +-65535.
  function automatic logic signed [16:0] clamp_pos(input logic signed [35:0] v);
    logic signed [16:0] res;
    if (v > 36'sd65535) begin
      res = 17'sd65535;
    end else if (v < -36'sd65535) begin
      res = -17'sd65535;
    end else begin
      res = v[16:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/uv_sphere_vertex_and_index_generator_top.sv
// Channel   Ports                          Handshake
// -------   -----------------------------  ------------------------------
// input     in_command, in_col_index, ...  accepted when in_push && !in_full
// result    out_pos_x ... out_last_of_run  accepted when out_pop && !out_empty
// config    cfg_index, cfg_data            written when cfg_valid && cfg_ready
//
// A quad command emits six index results, one per cycle while the result queue
// is not full, and quads follow each other with no gap. A vertex command waits
// on the bit-serial u and v dividers (17 quotient bits), then runs two
// sine/cosine evaluations and the normal and position products, all on one
// shared 33x33 multiplier.
// Reset is synchronous and active low; it empties both queues and restores
// the register defaults. A stalled result side fills the four-entry result
// queue and then the four-entry command queue before in_full rises.
`default_nettype none

module uv_sphere_vertex_and_index_generator_top
  import uvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_command,
  input  wire logic [8:0]         in_col_index,
  input  wire logic [8:0]         in_row_index,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic signed [15:0]      out_norm_x,
  output logic signed [15:0]      out_norm_y,
  output logic signed [15:0]      out_norm_z,
  output logic [16:0]             out_tex_u,
  output logic [16:0]             out_tex_v,
  output logic signed [15:0]      out_tan_x,
  output logic signed [15:0]      out_tan_z,
  output logic [16:0]             out_vertex_index,
  output logic                    out_last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  uvs_cfg_t   cfg;
  uvs_qhead_t head;
  logic       q_pop;
  uvs_res_t   res;

  // Front end: configuration, clamping, index forming, command queue.
  uvs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_command   (in_command),
    .in_col_index (in_col_index),
    .in_row_index (in_row_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .head         (head),
    .q_pop        (q_pop)
  );

  // Back end: vertex arithmetic, quad index runs, result queue.
  uvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_pos_x        = res.pos_x;
  assign out_pos_y        = res.pos_y;
  assign out_pos_z        = res.pos_z;
  assign out_norm_x       = res.norm_x;
  assign out_norm_y       = res.norm_y;
  assign out_norm_z       = res.norm_z;
  assign out_tex_u        = res.tex_u;
  assign out_tex_v        = res.tex_v;
  assign out_tan_x        = res.tan_x;
  assign out_tan_z        = res.tan_z;
  assign out_vertex_index = res.vertex_index;
  assign out_last_of_run  = res.last_of_run;

endmodule

`default_nettype wire

// File: src/uvs_div.sv
`default_nettype none

module uvs_div
  import uvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [8:0]  num,
  input  wire logic [8:0]  den,
  output logic             busy,
  output logic [16:0]      quot
);

  logic [DivCntW-1:0] cnt_r;
  logic [9:0]         rem_r;
  logic [16:0]        quot_r;
  logic               bit_q;
  logic [9:0]         rem_t;

  // One quotient bit per cycle of floor(num * 2^16 / den), num <= den.
  always_comb begin
    bit_q = (rem_r >= {1'b0, den});
    rem_t = bit_q ? (rem_r - {1'b0, den}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DivCntW'(DivSteps);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - DivCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= {rem_t[8:0], 1'b0};
      quot_r <= {quot_r[15:0], bit_q};
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: src/uvs_front.sv
`default_nettype none

module uvs_front
  import uvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [8:0]  in_col_index,
  input  wire logic [8:0]  in_row_index,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output uvs_cfg_t         cfg,
  output uvs_qhead_t       head,
  input  wire logic        q_pop
);

  logic [8:0]  col_segs_r;
  logic [8:0]  row_segs_r;
  logic [15:0] radius_r;

  uvs_item_t       mem_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW:0]   count_r;

  logic       push_ok;
  logic [8:0] col_lim;
  logic [8:0] row_lim;
  logic [8:0] col_c;
  logic [8:0] row_c;
  logic [9:0] cols_p1;
  logic [18:0] prod;
  uvs_item_t  item;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_segs_r <= 9'd32;
      row_segs_r <= 9'd16;
      radius_r   <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COL_SEGS: col_segs_r <= cfg_data[8:0];
        REG_ROW_SEGS: row_segs_r <= cfg_data[8:0];
        REG_RADIUS:   radius_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cols   = seg_count(col_segs_r);
    cfg.rows   = seg_count(row_segs_r);
    cfg.radius = radius_r;
  end

  // Clamp the grid point and form its flat index.
  always_comb begin
    if (uvs_cmd_t'(in_command) == CMD_QUAD) begin
      col_lim = cfg.cols - 9'd1;
      row_lim = cfg.rows - 9'd1;
    end else begin
      col_lim = cfg.cols;
      row_lim = cfg.rows;
    end
    col_c   = (in_col_index > col_lim) ? col_lim : in_col_index;
    row_c   = (in_row_index > row_lim) ? row_lim : in_row_index;
    cols_p1 = {1'b0, cfg.cols} + 10'd1;
    prod    = {10'b0, row_c} * {9'b0, cols_p1};
    item.cmd = uvs_cmd_t'(in_command);
    item.col = col_c;
    item.row = row_c;
    item.idx = prod[16:0] + {8'b0, col_c};
  end

  // Command queue.
  assign in_full = (count_r == (QPtrW + 1)'(QueueDepth));
  assign push_ok = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      if (push_ok && !q_pop) begin
        count_r <= count_r + (QPtrW + 1)'(1);
      end else if (!push_ok && q_pop) begin
        count_r <= count_r - (QPtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: src/uvs_back.sv
`default_nettype none

module uvs_back
  import uvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire uvs_cfg_t   cfg,
  input  wire uvs_qhead_t head,
  output logic            q_pop,
  output logic            out_empty,
  input  wire logic       out_pop,
  output uvs_res_t        res
);

  uvs_bk_state_t state_r;
  uvs_bk_state_t state_nxt;

  uvs_item_t          item_r;
  logic [2:0]         cnt_r;
  logic [2:0]         ci_r;
  logic               angle_r;
  logic signed [65:0] p_r;
  logic signed [65:0] p_nxt;
  logic [29:0]        x_r;
  logic [29:0]        x2_r;
  logic [30:0]        num_r;
  logic [30:0]        t_r;
  logic [30:0]        s_r;
  logic signed [31:0] su_r;
  logic signed [31:0] cu_r;
  logic signed [31:0] sv_r;
  logic signed [31:0] cv_r;
  logic signed [31:0] nx_r;
  logic signed [31:0] nz_r;
  logic signed [16:0] posx_r;
  logic signed [16:0] posy_r;

  uvs_res_t         omem_r [QueueDepth];
  logic [QPtrW-1:0] owr_r;
  logic [QPtrW-1:0] ord_r;
  logic [QPtrW:0]   ocount_r;
  logic             ofull;
  logic             opush;
  logic             opop;
  uvs_res_t         ores;

  logic        take;
  logic        div_start;
  logic        u_busy;
  logic        v_busy;
  logic [16:0] u_q;
  logic [16:0] v_q;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  logic [31:0] ph;
  logic [1:0]  quad;
  logic        swap;
  logic [30:0] a31;
  logic [28:0] q0;
  logic [5:0]  dcoef;
  logic [34:0] q0d;
  logic [34:0] rem;
  logic [29:0] qc;
  logic [30:0] t_nxt;
  logic [30:0] c_val;
  logic [30:0] s_sw;
  logic [30:0] c_sw;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic [16:0] i1;
  logic [16:0] i2;
  logic [16:0] i3;

  // Texture coordinate dividers, u and v in parallel.
  uvs_div u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (head.item.col),
    .den   (cfg.cols),
    .busy  (u_busy),
    .quot  (u_q)
  );

  uvs_div u_div_v (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (head.item.row),
    .den   (cfg.rows),
    .busy  (v_busy),
    .quot  (v_q)
  );

  // Result queue.
  assign ofull     = (ocount_r == (QPtrW + 1)'(QueueDepth));
  assign out_empty = (ocount_r == '0);
  assign opop      = out_pop && !out_empty;
  assign res       = omem_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r    <= '0;
      ord_r    <= '0;
      ocount_r <= '0;
    end else begin
      if (opush) begin
        owr_r <= owr_r + QPtrW'(1);
      end
      if (opop) begin
        ord_r <= ord_r + QPtrW'(1);
      end
      if (opush && !opop) begin
        ocount_r <= ocount_r + (QPtrW + 1)'(1);
      end else if (!opush && opop) begin
        ocount_r <= ocount_r - (QPtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      omem_r[owr_r] <= ores;
    end
  end

  // Angle reduction for the current angle.
  always_comb begin
    ph    = angle_r ? {v_q, 15'b0} : {u_q[15:0], 16'b0};
    quad  = ph[31:30];
    swap  = (ph[29:0] > EIGHTH_TURN);
    a31   = swap ? (Q30_ONE - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
  end

  // Division by a Horner constant: reciprocal product and one correction.
  always_comb begin
    q0    = p_r[60:32];
    dcoef = coef_div(ci_r);
    q0d   = {6'b0, q0} * {29'b0, dcoef};
    rem   = {4'b0, num_r} - q0d;
    qc    = {1'b0, q0} + ((rem >= {29'b0, dcoef}) ? 30'd1 : 30'd0);
    t_nxt = Q30_ONE - {1'b0, qc};
  end

  // Final cosine term, octant swap and quadrant signs.
  always_comb begin
    c_val = Q30_ONE - {1'b0, p_r[60:31]};
    s_sw  = swap ? c_val : s_r;
    c_sw  = swap ? s_r : c_val;
    unique case (quad)
      2'd0: begin
        sn = $signed({1'b0, s_sw});
        cs = $signed({1'b0, c_sw});
      end
      2'd1: begin
        sn = $signed({1'b0, c_sw});
        cs = -$signed({1'b0, s_sw});
      end
      2'd2: begin
        sn = -$signed({1'b0, s_sw});
        cs = -$signed({1'b0, c_sw});
      end
      default: begin
        sn = -$signed({1'b0, c_sw});
        cs = $signed({1'b0, s_sw});
      end
    endcase
  end

  // Take a new command when idle or as a quad hands over its last index.
  assign take = head.valid &&
                ((state_r == BK_IDLE) ||
                 ((state_r == BK_QUAD) && (cnt_r == 3'd5) && !ofull));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE, BK_QUAD: begin
        if (take) begin
          state_nxt = (head.item.cmd == CMD_QUAD) ? BK_QUAD : BK_DIV;
        end else if ((state_r == BK_QUAD) && !ofull && (cnt_r == 3'd5)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (!u_busy && !v_busy) begin
          state_nxt = BK_SC_MX;
        end
      end
      BK_SC_MX:  state_nxt = BK_SC_MX2;
      BK_SC_MX2: state_nxt = BK_SC_X2;
      BK_SC_X2:  state_nxt = BK_DM;
      BK_DM:     state_nxt = BK_DC;
      BK_DC:     state_nxt = (ci_r == 3'd2) ? BK_SFIN : BK_HM;
      BK_HM:     state_nxt = (ci_r == 3'd6) ? BK_CFIN : BK_HN;
      BK_HN:     state_nxt = BK_DM;
      BK_SFIN:   state_nxt = BK_SSTORE;
      BK_SSTORE: state_nxt = BK_DM;
      BK_CFIN:   state_nxt = angle_r ? BK_NX : BK_SC_MX;
      BK_NX:     state_nxt = BK_NZ;
      BK_NZ:     state_nxt = BK_PX;
      BK_PX:     state_nxt = BK_PY;
      BK_PY:     state_nxt = BK_PZ;
      BK_PZ:     state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!ofull) begin
          state_nxt = BK_IDLE;
        end
      end
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier operands, handshakes, result.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    q_pop     = take;
    div_start = take && (head.item.cmd == CMD_VERTEX);
    opush     = 1'b0;
    i1        = item_r.idx + 17'd1;
    i2        = item_r.idx + {8'b0, cfg.cols} + 17'd1;
    i3        = i2 + 17'd1;
    ores      = '0;
    unique case (state_r)
      BK_SC_MX: begin
        mul_a = $signed({3'b0, a31[29:0]});
        mul_b = $signed({2'b0, HALF_PI_Q30});
      end
      BK_SC_MX2: begin
        mul_a = $signed({3'b0, p_r[59:30]});
        mul_b = $signed({3'b0, p_r[59:30]});
      end
      BK_DM: begin
        mul_a = $signed({2'b0, num_r});
        mul_b = $signed({3'b0, coef_recip(ci_r)});
      end
      BK_HM: begin
        mul_a = $signed({3'b0, x2_r});
        mul_b = $signed({2'b0, t_r});
      end
      BK_SFIN: begin
        mul_a = $signed({3'b0, x_r});
        mul_b = $signed({2'b0, t_r});
      end
      BK_NX: begin
        mul_a = {cu_r[31], cu_r};
        mul_b = {sv_r[31], sv_r};
      end
      BK_NZ: begin
        mul_a = {su_r[31], su_r};
        mul_b = {sv_r[31], sv_r};
      end
      BK_PX: begin
        mul_a = {nx_r[31], nx_r};
        mul_b = $signed({17'b0, cfg.radius});
      end
      BK_PY: begin
        mul_a = {cv_r[31], cv_r};
        mul_b = $signed({17'b0, cfg.radius});
      end
      BK_PZ: begin
        mul_a = {nz_r[31], nz_r};
        mul_b = $signed({17'b0, cfg.radius});
      end
      BK_QUAD: begin
        opush = !ofull;
        unique case (cnt_r)
          3'd0:    ores.vertex_index = item_r.idx;
          3'd1:    ores.vertex_index = i1;
          3'd2:    ores.vertex_index = i2;
          3'd3:    ores.vertex_index = i1;
          3'd4:    ores.vertex_index = i3;
          default: ores.vertex_index = i2;
        endcase
        ores.last_of_run = (cnt_r == 3'd5);
      end
      BK_EMIT: begin
        opush             = !ofull;
        ores.pos_x        = posx_r;
        ores.pos_y        = posy_r;
        ores.pos_z        = clamp_pos(rnd30(p_r));
        ores.norm_x       = sat_q15(nx_r);
        ores.norm_y       = sat_q15(cv_r);
        ores.norm_z       = sat_q15(nz_r);
        ores.tex_u        = u_q;
        ores.tex_v        = v_q;
        ores.tan_x        = sat_q15(-su_r);
        ores.tan_z        = sat_q15(cu_r);
        ores.vertex_index = item_r.idx;
        ores.last_of_run  = 1'b1;
      end
      default: ;
    endcase
  end

  assign p_nxt = mul_a * mul_b;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        cnt_r <= '0;
      end else if ((state_r == BK_QUAD) && !ofull) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // Datapath registers of the shared multiplier sequence.
  always_ff @(posedge clk) begin
    if (state_r != BK_EMIT) begin
      p_r <= p_nxt;
    end
    if (take) begin
      item_r  <= head.item;
      angle_r <= 1'b0;
    end
    unique case (state_r)
      BK_SC_MX2: x_r <= p_r[59:30];
      BK_SC_X2: begin
        x2_r  <= p_r[59:30];
        num_r <= {1'b0, p_r[59:30]};
        ci_r  <= 3'd0;
      end
      BK_DC: begin
        t_r  <= t_nxt;
        ci_r <= ci_r + 3'd1;
      end
      BK_HN: num_r <= p_r[60:30];
      BK_SSTORE: begin
        s_r   <= p_r[60:30];
        num_r <= {1'b0, x2_r};
      end
      BK_CFIN: begin
        if (angle_r) begin
          sv_r <= sn;
          cv_r <= cs;
        end else begin
          su_r    <= sn;
          cu_r    <= cs;
          angle_r <= 1'b1;
        end
      end
      BK_NZ: nx_r   <= 32'(rnd30(p_r));
      BK_PX: nz_r   <= 32'(rnd30(p_r));
      BK_PY: posx_r <= clamp_pos(rnd30(p_r));
      BK_PZ: posy_r <= clamp_pos(rnd30(p_r));
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/uvs_checker.sv
`default_nettype none

module uvs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic signed [16:0] out_pos_x,
  input wire logic signed [16:0] out_pos_y,
  input wire logic signed [16:0] out_pos_z,
  input wire logic signed [15:0] out_norm_x,
  input wire logic signed [15:0] out_norm_y,
  input wire logic signed [15:0] out_norm_z,
  input wire logic [16:0]        out_tex_u,
  input wire logic [16:0]        out_tex_v,
  input wire logic signed [15:0] out_tan_x,
  input wire logic signed [15:0] out_tan_z,
  input wire logic [16:0]        out_vertex_index,
  input wire logic               out_last_of_run
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A waiting result holds until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_vertex_index) && $stable(out_last_of_run)
       && $stable(out_pos_x)))
    else $error("waiting result changed");

  // Only quad index results are not last; they carry no geometry.
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last_of_run) |->
      (out_pos_x == 17'sd0 && out_pos_y == 17'sd0 && out_pos_z == 17'sd0 &&
       out_norm_x == 16'sd0 && out_norm_y == 16'sd0 && out_norm_z == 16'sd0 &&
       out_tex_u == 17'd0 && out_tex_v == 17'd0 &&
       out_tan_x == 16'sd0 && out_tan_z == 16'sd0))
    else $error("index result carries geometry");

  // Texture coordinates never exceed one.
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536))
    else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_and_index_generator_top uvs_checker u_uvs_checker (.*);

`default_nettype wire
